// File: rtl/c402seq_pkg.sv
// c402seq_pkg: types, codes and constants of the cia402 drive enable sequencer
// depends on nothing; used by every module of the block by scoped names
package c402seq_pkg;

  localparam int unsigned SwWidth  = 16;
  localparam int unsigned CwWidth  = 16;
  localparam int unsigned PosWidth = 32;
  localparam int unsigned StepWidth  = 16;
  localparam int unsigned PulseWidth = 8;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [StepWidth-1:0]  StepLimitReset = 16'd3000;
  localparam logic [PulseWidth-1:0] HalfPeriodReset = 8'd10;

  // statusword decoding
  localparam logic [SwWidth-1:0] SwFaultBit    = 16'h0008;
  localparam logic [SwWidth-1:0] SwMaskSod     = 16'h004F;
  localparam logic [SwWidth-1:0] SwSod         = 16'h0040;
  localparam logic [SwWidth-1:0] SwMaskState   = 16'h006F;
  localparam logic [SwWidth-1:0] SwReadyOn     = 16'h0021;
  localparam logic [SwWidth-1:0] SwSwitchedOn  = 16'h0023;
  localparam logic [SwWidth-1:0] SwOpEnabled   = 16'h0027;

  // controlwords
  localparam logic [CwWidth-1:0] CwNone        = 16'h0000;
  localparam logic [CwWidth-1:0] CwFaultReset  = 16'h0080;
  localparam logic [CwWidth-1:0] CwShutdown    = 16'h0006;
  localparam logic [CwWidth-1:0] CwSwitchOn    = 16'h0007;
  localparam logic [CwWidth-1:0] CwEnableOp    = 16'h000F;

  typedef enum logic [1:0] {
    FUNC_ENABLE  = 2'd0,
    FUNC_RUN     = 2'd1,
    FUNC_PARK    = 2'd2,
    FUNC_DISABLE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SEQ_BUSY    = 2'd0,
    SEQ_ENABLED = 2'd1,
    SEQ_TIMEOUT = 2'd2
  } seq_status_t;

  typedef enum logic {
    REG_STEP_LIMIT  = 1'b0,
    REG_HALF_PERIOD = 1'b1
  } reg_index_t;

  typedef struct packed {
    func_t                       func;
    logic [SwWidth-1:0]          status_word;
    logic signed [PosWidth-1:0]  actual_position;
    logic signed [PosWidth-1:0]  commanded_position;
  } item_t;

  typedef struct packed {
    logic [CwWidth-1:0]          control_word;
    logic signed [PosWidth-1:0]  target_out;
    seq_status_t                 seq_status;
    logic                        is_enabled;
  } result_t;

  typedef struct packed {
    logic [StepWidth-1:0]  step_count;
    logic [PulseWidth-1:0] pulse_count;
    logic                  pulse_level;
    logic                  enabled_flag;
  } seq_state_t;

  typedef struct packed {
    logic [StepWidth-1:0]  step_limit;
    logic [PulseWidth-1:0] half_period;
  } cfg_t;

endpackage

// File: rtl/c402seq_decode.sv
// c402seq_decode: statusword decoding and sequence state update for one word
// depends on c402seq_pkg
module c402seq_decode (
  input  c402seq_pkg::item_t      item,
  input  c402seq_pkg::seq_state_t state,
  input  c402seq_pkg::cfg_t       cfg,
  output c402seq_pkg::result_t    result,
  output c402seq_pkg::seq_state_t state_next
);

  logic [c402seq_pkg::CwWidth-1:0]      cw_dec;
  logic                                 done;
  logic [c402seq_pkg::PulseWidth:0]     pulse_inc;
  logic [c402seq_pkg::StepWidth:0]      step_inc;
  logic [c402seq_pkg::SwWidth-1:0]      sw_state;

  always_comb begin
    sw_state = item.status_word & c402seq_pkg::SwMaskState;
    done     = 1'b0;
    if ((item.status_word & c402seq_pkg::SwFaultBit) != '0) begin
      cw_dec = state.pulse_level ? c402seq_pkg::CwFaultReset : c402seq_pkg::CwNone;
    end else if ((item.status_word & c402seq_pkg::SwMaskSod) == c402seq_pkg::SwSod) begin
      cw_dec = c402seq_pkg::CwShutdown;
    end else if (sw_state == c402seq_pkg::SwReadyOn) begin
      cw_dec = c402seq_pkg::CwSwitchOn;
    end else if (sw_state == c402seq_pkg::SwSwitchedOn) begin
      cw_dec = c402seq_pkg::CwEnableOp;
    end else if (sw_state == c402seq_pkg::SwOpEnabled) begin
      cw_dec = c402seq_pkg::CwEnableOp;
      done   = 1'b1;
    end else begin
      cw_dec = c402seq_pkg::CwNone;
    end
  end

  assign pulse_inc = {1'b0, state.pulse_count} + 1'b1;
  assign step_inc  = {1'b0, state.step_count} + 1'b1;

  always_comb begin
    state_next            = state;
    result.control_word   = c402seq_pkg::CwNone;
    result.target_out     = item.actual_position;
    result.seq_status     = c402seq_pkg::SEQ_BUSY;
    case (item.func)
      c402seq_pkg::FUNC_ENABLE: begin
        result.control_word = cw_dec;
        if (pulse_inc >= {1'b0, cfg.half_period}) begin
          state_next.pulse_count = '0;
          state_next.pulse_level = ~state.pulse_level;
        end else begin
          state_next.pulse_count = pulse_inc[c402seq_pkg::PulseWidth-1:0];
        end
        if (done) begin
          state_next.enabled_flag = 1'b1;
          result.seq_status       = c402seq_pkg::SEQ_ENABLED;
        end else if (step_inc >= {1'b0, cfg.step_limit}) begin
          result.seq_status       = c402seq_pkg::SEQ_TIMEOUT;
        end else begin
          state_next.step_count   = step_inc[c402seq_pkg::StepWidth-1:0];
        end
        if (done || result.seq_status == c402seq_pkg::SEQ_TIMEOUT) begin
          state_next.step_count  = '0;
          state_next.pulse_count = '0;
          state_next.pulse_level = 1'b0;
        end
      end
      c402seq_pkg::FUNC_RUN: begin
        state_next.step_count  = '0;
        state_next.pulse_count = '0;
        state_next.pulse_level = 1'b0;
        if (state.enabled_flag) begin
          result.control_word = c402seq_pkg::CwEnableOp;
          result.target_out   = item.commanded_position;
        end else begin
          result.control_word = c402seq_pkg::CwShutdown;
        end
      end
      c402seq_pkg::FUNC_PARK: begin
        state_next.step_count  = '0;
        state_next.pulse_count = '0;
        state_next.pulse_level = 1'b0;
        result.control_word    = c402seq_pkg::CwNone;
      end
      default: begin
        state_next.step_count   = '0;
        state_next.pulse_count  = '0;
        state_next.pulse_level  = 1'b0;
        state_next.enabled_flag = 1'b0;
        result.control_word     = c402seq_pkg::CwShutdown;
      end
    endcase
    result.is_enabled = state_next.enabled_flag;
  end

endmodule

// File: rtl/c402seq_out_reg.sv
// c402seq_out_reg: result register with valid and stall towards the consumer
// depends on c402seq_pkg
module c402seq_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  c402seq_pkg::result_t load_data,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c402seq_pkg::result_t out_data
);

  logic                 valid;
  c402seq_pkg::result_t data;

  assign can_load  = ~valid | ~out_stall;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data <= load_data;
    end
  end

endmodule

// File: rtl/cia402_drive_enable_sequencer.sv
// cia402_drive_enable_sequencer: top level with input register, state and config registers
// depends on c402seq_pkg, c402seq_decode and c402seq_out_reg
//
// One word per process-data cycle: a word accepted on the input channel is held in an
// input register, decoded against the sequence state in a single pass of logic and
// placed in the result register; a new word is taken every cycle while the output side
// keeps up. in_stall rises only while both registers hold words and out_stall is high.
// The user must write the step limit and fault-reset half period through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
module cia402_drive_enable_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] status_word,
  input  logic signed [31:0] actual_position,
  input  logic signed [31:0] commanded_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] control_word,
  output logic signed [31:0] target_out,
  output logic [1:0]  seq_status,
  output logic        is_enabled
);

  c402seq_pkg::cfg_t       cfg;
  c402seq_pkg::seq_state_t state;
  c402seq_pkg::seq_state_t state_next;
  c402seq_pkg::item_t      item;
  logic                    item_valid;
  c402seq_pkg::result_t    result;
  c402seq_pkg::result_t    out_data;
  logic                    can_load;
  logic                    advance;

  assign in_stall = item_valid & ~can_load;
  assign advance  = item_valid & can_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_limit  <= c402seq_pkg::StepLimitReset;
      cfg.half_period <= c402seq_pkg::HalfPeriodReset;
    end else if (cfg_we) begin
      case (c402seq_pkg::reg_index_t'(cfg_index))
        c402seq_pkg::REG_STEP_LIMIT:  cfg.step_limit  <= cfg_data;
        c402seq_pkg::REG_HALF_PERIOD: cfg.half_period <= cfg_data[c402seq_pkg::PulseWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.func               <= c402seq_pkg::func_t'(func);
      item.status_word        <= status_word;
      item.actual_position    <= actual_position;
      item.commanded_position <= commanded_position;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  c402seq_decode u_decode (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .result     (result),
    .state_next (state_next)
  );

  c402seq_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (item_valid),
    .load_data  (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign control_word = out_data.control_word;
  assign target_out   = out_data.target_out;
  assign seq_status   = out_data.seq_status;
  assign is_enabled   = out_data.is_enabled;

endmodule

// File: dv/tb.sv
// tb: self-checking regression of the cia402 drive enable sequencer, a scoreboard class
// predicts each controlword, target and enable status from the accepted input words
// depends on c402seq_pkg and cia402_drive_enable_sequencer

class controlword_book;
  logic [c402seq_pkg::StepWidth-1:0]  step_limit;
  logic [c402seq_pkg::PulseWidth-1:0] half_period;
  logic [c402seq_pkg::StepWidth-1:0]  step_count;
  logic [c402seq_pkg::PulseWidth-1:0] pulse_count;
  logic                               pulse_level;
  logic                               enabled_flag;
  c402seq_pkg::result_t               expected_words[$];
  int                                 errors;

  function new();
    step_limit   = c402seq_pkg::StepLimitReset;
    half_period  = c402seq_pkg::HalfPeriodReset;
    step_count   = '0;
    pulse_count  = '0;
    pulse_level  = 1'b0;
    enabled_flag = 1'b0;
    errors       = 0;
  endfunction

  function void abort_sequence();
    step_count  = '0;
    pulse_count = '0;
    pulse_level = 1'b0;
  endfunction

  task report_mismatch(input string what);
    $display("error: %s", what);
    errors++;
  endtask

  task predict_word(input c402seq_pkg::item_t it);
    c402seq_pkg::result_t              r;
    logic                              done;
    logic [c402seq_pkg::StepWidth:0]   next_steps;
    logic [c402seq_pkg::SwWidth-1:0]   sw;
    sw           = it.status_word;
    done         = 1'b0;
    r.target_out = it.actual_position;
    r.seq_status = c402seq_pkg::SEQ_BUSY;
    case (it.func)
      c402seq_pkg::FUNC_ENABLE: begin
        if ((sw & c402seq_pkg::SwFaultBit) != '0) begin
          r.control_word = pulse_level ? c402seq_pkg::CwFaultReset : c402seq_pkg::CwNone;
        end else if ((sw & c402seq_pkg::SwMaskSod) == c402seq_pkg::SwSod) begin
          r.control_word = c402seq_pkg::CwShutdown;
        end else if ((sw & c402seq_pkg::SwMaskState) == c402seq_pkg::SwReadyOn) begin
          r.control_word = c402seq_pkg::CwSwitchOn;
        end else if ((sw & c402seq_pkg::SwMaskState) == c402seq_pkg::SwSwitchedOn) begin
          r.control_word = c402seq_pkg::CwEnableOp;
        end else if ((sw & c402seq_pkg::SwMaskState) == c402seq_pkg::SwOpEnabled) begin
          r.control_word = c402seq_pkg::CwEnableOp;
          done = 1'b1;
        end else begin
          r.control_word = c402seq_pkg::CwNone;
        end
        // a zero half period behaves as one
        if ({1'b0, pulse_count} + 9'd1 >= {1'b0, half_period}) begin
          pulse_count = '0;
          pulse_level = ~pulse_level;
        end else begin
          pulse_count = pulse_count + 1'b1;
        end
        next_steps = {1'b0, step_count} + 17'd1;
        if (done) begin
          enabled_flag = 1'b1;
          r.seq_status = c402seq_pkg::SEQ_ENABLED;
          abort_sequence();
        end else if (next_steps >= {1'b0, step_limit}) begin
          r.seq_status = c402seq_pkg::SEQ_TIMEOUT;
          abort_sequence();
        end else begin
          step_count = next_steps[c402seq_pkg::StepWidth-1:0];
        end
      end
      c402seq_pkg::FUNC_RUN: begin
        abort_sequence();
        if (enabled_flag) begin
          r.control_word = c402seq_pkg::CwEnableOp;
          r.target_out   = it.commanded_position;
        end else begin
          r.control_word = c402seq_pkg::CwShutdown;
        end
      end
      c402seq_pkg::FUNC_PARK: begin
        abort_sequence();
        r.control_word = c402seq_pkg::CwNone;
      end
      default: begin
        abort_sequence();
        enabled_flag   = 1'b0;
        r.control_word = c402seq_pkg::CwShutdown;
      end
    endcase
    r.is_enabled = enabled_flag;
    expected_words.push_back(r);
  endtask

  task check_word(input c402seq_pkg::result_t got);
    c402seq_pkg::result_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with nothing expected");
    end else begin
      want = expected_words.pop_front();
      if (got.control_word !== want.control_word)
        report_mismatch($sformatf("control_word %h, expected %h",
                                  got.control_word, want.control_word));
      if (got.target_out !== want.target_out)
        report_mismatch($sformatf("target_out %h, expected %h",
                                  got.target_out, want.target_out));
      if (got.seq_status !== want.seq_status)
        report_mismatch($sformatf("seq_status %0d, expected %0d",
                                  got.seq_status, want.seq_status));
      if (got.is_enabled !== want.is_enabled)
        report_mismatch($sformatf("is_enabled %b, expected %b",
                                  got.is_enabled, want.is_enabled));
    end
  endtask
endclass

module tb;
  localparam int CycleLimit = 400000;

  logic                                    clk;
  logic                                    rst = 1'b1;
  logic                                    cfg_we = 1'b0;
  c402seq_pkg::reg_index_t                 cfg_index = c402seq_pkg::REG_STEP_LIMIT;
  logic [c402seq_pkg::CfgDataWidth-1:0]    cfg_data = '0;
  logic                                    in_valid = 1'b0;
  logic                                    in_stall;
  logic [1:0]                              func = '0;
  logic [c402seq_pkg::SwWidth-1:0]         status_word = '0;
  logic signed [c402seq_pkg::PosWidth-1:0] actual_position = '0;
  logic signed [c402seq_pkg::PosWidth-1:0] commanded_position = '0;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  logic [c402seq_pkg::CwWidth-1:0]         control_word;
  logic signed [c402seq_pkg::PosWidth-1:0] target_out;
  logic [1:0]                              seq_status;
  logic                                    is_enabled;

  controlword_book book = new();
  bit no_idle = 1'b0;
  bit hold_off_request = 1'b0;
  int items_sent = 0;
  int cycles = 0;

  cia402_drive_enable_sequencer i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .status_word        (status_word),
    .actual_position    (actual_position),
    .commanded_position (commanded_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .control_word       (control_word),
    .target_out         (target_out),
    .seq_status         (seq_status),
    .is_enabled         (is_enabled)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("cia402_drive_enable_sequencer regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    c402seq_pkg::item_t   seen;
    c402seq_pkg::result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.func               = c402seq_pkg::func_t'(func);
        seen.status_word        = status_word;
        seen.actual_position    = actual_position;
        seen.commanded_position = commanded_position;
        book.predict_word(seen);
      end
      if (out_valid && !out_stall) begin
        got.control_word = control_word;
        got.target_out   = target_out;
        got.seq_status   = c402seq_pkg::seq_status_t'(seq_status);
        got.is_enabled   = is_enabled;
        book.check_word(got);
      end
    end
  end

  // receiver: random stall per word, one long hold-off on request
  initial begin : receiver
    int wait_cycles;
    @(negedge clk);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_off_request) begin
        wait_cycles      = 64;
        hold_off_request = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic [c402seq_pkg::SwWidth-1:0] sw_with(
      input logic [c402seq_pkg::SwWidth-1:0] mask,
      input logic [c402seq_pkg::SwWidth-1:0] pattern);
    return (16'($urandom) & ~mask) | pattern;
  endfunction

  function automatic logic [c402seq_pkg::PosWidth-1:0] any_position();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input c402seq_pkg::func_t f,
                           input logic [c402seq_pkg::SwWidth-1:0] sw,
                           input logic [c402seq_pkg::PosWidth-1:0] act,
                           input logic [c402seq_pkg::PosWidth-1:0] cmd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    func               <= f;
    status_word        <= sw;
    actual_position    <= act;
    commanded_position <= cmd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(c402seq_pkg::func_t'($urandom_range(0, 3)), 16'($urandom),
              any_position(), any_position());
  endtask

  task automatic enable_step(input logic [c402seq_pkg::SwWidth-1:0] sw);
    if ($urandom_range(0, 15) == 0) begin
      send_noise();
    end
    send_item(c402seq_pkg::FUNC_ENABLE, sw, any_position(), any_position());
  endtask

  // fault, switch on disabled, ready, switched on, op enabled, run, park or disable
  task automatic drive_sequence();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) enable_step(sw_with(c402seq_pkg::SwFaultBit, c402seq_pkg::SwFaultBit));
    end
    n = $urandom_range(1, 3);
    repeat (n) enable_step(sw_with(c402seq_pkg::SwMaskSod, c402seq_pkg::SwSod));
    n = $urandom_range(1, 3);
    repeat (n) enable_step(sw_with(c402seq_pkg::SwMaskState, c402seq_pkg::SwReadyOn));
    n = $urandom_range(1, 3);
    repeat (n) enable_step(sw_with(c402seq_pkg::SwMaskState, c402seq_pkg::SwSwitchedOn));
    enable_step(sw_with(c402seq_pkg::SwMaskState, c402seq_pkg::SwOpEnabled));
    n = $urandom_range(0, 6);
    repeat (n) begin
      send_item(c402seq_pkg::FUNC_RUN, 16'($urandom), any_position(), any_position());
    end
    case ($urandom_range(0, 3))
      0: begin
        send_item(c402seq_pkg::FUNC_PARK, 16'($urandom), any_position(), any_position());
      end
      1, 2: begin
        send_item(c402seq_pkg::FUNC_DISABLE, 16'($urandom), any_position(),
                  any_position());
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic [c402seq_pkg::StepWidth-1:0] limit,
                              input logic [c402seq_pkg::PulseWidth-1:0] half);
    cfg_we    <= 1'b1;
    cfg_index <= c402seq_pkg::REG_STEP_LIMIT;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_index <= c402seq_pkg::REG_HALF_PERIOD;
    cfg_data  <= {8'($urandom), half};
    @(negedge clk);
    cfg_we <= 1'b0;
    book.step_limit  = limit;
    book.half_period = half;
  endtask

  task automatic run_phase(input logic [c402seq_pkg::StepWidth-1:0] limit,
                           input logic [c402seq_pkg::PulseWidth-1:0] half,
                           input int count, input bit quiet, input bit hold);
    int target;
    write_config(limit, half);
    no_idle = quiet;
    if (hold) begin
      hold_off_request = 1'b1;
    end
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        drive_sequence();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words at reset settings
    send_item(c402seq_pkg::FUNC_RUN, 16'h0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(c402seq_pkg::FUNC_PARK, 16'hffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0008, 32'h0000_0000, 32'hffff_ffff);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'hffff, 32'hffff_ffff, 32'h0000_0000);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0040, 32'h1234_5678, 32'h0);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0021, 32'h8000_0000, 32'h0);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0023, 32'h7fff_ffff, 32'h0);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0027, 32'h0000_0001, 32'h0);
    send_item(c402seq_pkg::FUNC_RUN, 16'h0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(c402seq_pkg::FUNC_RUN, 16'hffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'hffb7, 32'h0, 32'h0);
    send_item(c402seq_pkg::FUNC_PARK, 16'h0000, 32'hdead_beef, 32'h0);
    send_item(c402seq_pkg::FUNC_DISABLE, 16'h0027, 32'h8000_0000, 32'h7fff_ffff);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0000, 32'h0, 32'h0);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0060, 32'h0, 32'h0);
    wait_drained();

    // fault-reset pulse toggling every step, short step limit
    write_config(16'd3, 8'd1);
    repeat (4) begin
      send_item(c402seq_pkg::FUNC_ENABLE, 16'h0008, any_position(), any_position());
    end
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0027, 32'h0, 32'h0);
    wait_drained();

    // zero limit and half period behave as one
    write_config(16'd0, 8'd0);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0040, 32'h0, 32'h0);
    send_item(c402seq_pkg::FUNC_ENABLE, 16'h0027, 32'h0, 32'h0);
    wait_drained();

    run_phase(16'd8, 8'd2, 90, 1'b0, 1'b0);
    run_phase(16'd40, 8'd3, 90, 1'b0, 1'b1);
    run_phase(16'd1, 8'd1, 60, 1'b1, 1'b0);
    run_phase(16'd0, 8'd0, 60, 1'b0, 1'b0);
    run_phase(16'd65535, 8'd255, 90, 1'b0, 1'b0);
    run_phase(16'd20, 8'd255, 90, 1'b1, 1'b0);
    run_phase(c402seq_pkg::StepLimitReset, c402seq_pkg::HalfPeriodReset, 90, 1'b0, 1'b0);
    run_phase(16'($urandom_range(1, 60)), 8'($urandom_range(1, 12)), 90, 1'b0, 1'b0);

    if (book.errors == 0 && book.expected_words.size() == 0) begin
      $display("cia402_drive_enable_sequencer regression: pass");
    end else begin
      $display("cia402_drive_enable_sequencer regression: fail");
    end
    $finish;
  end
endmodule
